[src/twg_pkg.sv]
// Package for the test waveform generator: sizes, codes and the quarter-wave sine table.
`default_nettype none

package twg_pkg;

    localparam int SINE_ENTRIES   = 256;
    localparam int COUNT_BITS     = 24;
    localparam int SINE_IDX_BITS  = $clog2(SINE_ENTRIES);
    localparam int VALUE_BITS     = 32;
    localparam int ELAPSED_BITS   = 10;
    localparam int PHASE_BITS     = 16;
    localparam int QUAD_SHIFT     = PHASE_BITS - 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int S_TDATA_BITS   = 48;
    localparam int M_TDATA_BITS   = 32;
    localparam int SINE_MAG_BITS  = 16;

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;
    localparam logic [SINE_MAG_BITS-1:0] SINE_FULL = '1;

    typedef enum logic [3:0] {
        MODE_HOLD      = 4'd0,
        MODE_RAMP      = 4'd1,
        MODE_RAMP_HOLD = 4'd2,
        MODE_TRIANGLE  = 4'd3,
        MODE_SINE      = 4'd4,
        MODE_ONE_SHOT  = 4'd5,
        MODE_N_SHOT    = 4'd6,
        MODE_PWM       = 4'd7,
        MODE_PWM_NOW   = 4'd8
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODE          = 3'd0,
        CFG_LEVEL_LOW     = 3'd1,
        CFG_LEVEL_HIGH    = 3'd2,
        CFG_SLOPE_OR_BIAS = 3'd3,
        CFG_PHASE_STEP    = 3'd4,
        CFG_COUNT_A       = 3'd5,
        CFG_COUNT_B       = 3'd6
    } cfg_index_t;

    typedef enum logic {
        REQ_TICK    = 1'b0,
        REQ_RESTART = 1'b1
    } req_type_t;

    typedef logic [SINE_MAG_BITS-1:0] sine_tab_t [SINE_ENTRIES];

    // Degree 15 Taylor series of sin(x) in Q2.30, evaluated at elaboration.
    function automatic logic [SINE_MAG_BITS-1:0] sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (64'(i) * 64'd1686629713) / SINE_ENTRIES;
        term = x;
        sum  = $signed(x);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 6;
        sum  = sum - $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 20;
        sum  = sum + $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 42;
        sum  = sum - $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 72;
        sum  = sum + $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 110;
        sum  = sum - $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 156;
        sum  = sum + $signed(term);
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / 210;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        r = ($unsigned(sum) * 64'd65535 + (64'd1 << 29)) >> 30;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[SINE_MAG_BITS-1:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t t;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

[src/test_waveform_generator.sv]
// Top level of the test waveform generator: input register, one compute stage, output register.
`default_nettype none

// An accepted item waits in the input register until the output register can take its result,
// and m_tdata shows the output register. Throughput: one item per cycle unless m_tready stalls.
// The input register, the single compute stage and the output register run as a pipeline, and
// the generator state updates as each item leaves.
// Reset (aresetn low at a clock edge) empties both registers, clears all configuration
// registers and the frame counter, phase and direction, and arms the first-tick hold.
module test_waveform_generator
    import twg_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input items.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata fields, lowest bit up: run, elapsed_ms[9:0], previous_value[31:0], zero pad.
    input  wire logic [S_TDATA_BITS-1:0]   s_tdata,
    // s_tuser fields, lowest bit up: req_type (tick or restart).
    input  wire logic                      s_tuser,
    // Result items.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata fields, lowest bit up: value[31:0].
    output logic [M_TDATA_BITS-1:0]        m_tdata,
    // Configuration writes.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data
);

    localparam int STEP_BITS     = VALUE_BITS + 1;
    localparam int STEP_PROD     = STEP_BITS + ELAPSED_BITS + 1;
    localparam int SUM_BITS      = STEP_PROD + 1;
    localparam int SINE_S_BITS   = SINE_MAG_BITS + 1;
    localparam int SINE_PROD     = SINE_S_BITS + VALUE_BITS;
    localparam int ROUND_BITS    = SINE_PROD - 16;
    localparam int BIAS_SUM      = ROUND_BITS + 1;
    localparam int IDX_PROD_BITS = QUAD_SHIFT + SINE_IDX_BITS + 1;
    localparam int PH_PROD_BITS  = PHASE_BITS + ELAPSED_BITS;

    // Configuration registers.
    mode_t                         mode_reg;
    logic signed [VALUE_BITS-1:0]  level_low_reg;
    logic signed [VALUE_BITS-1:0]  level_high_reg;
    logic signed [VALUE_BITS-1:0]  slope_reg;
    logic [PHASE_BITS-1:0]         phase_step_reg;
    logic [COUNT_BITS-1:0]         count_a_reg;
    logic [COUNT_BITS-1:0]         count_b_reg;

    // Generator state.
    logic [COUNT_BITS-1:0]         frame_count_reg, frame_count_next;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic                          falling_reg, falling_next;
    logic                          first_tick_reg, first_tick_next;

    // Input and output registers.
    logic                          in_valid_reg, in_valid_next;
    req_type_t                     in_req_reg;
    logic                          in_run_reg;
    logic [ELAPSED_BITS-1:0]       in_elapsed_reg;
    logic signed [VALUE_BITS-1:0]  in_prev_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0]  out_value_reg;

    logic                          s_accept;
    logic                          out_ready;
    logic                          fire;
    logic                          cfg_we;

    // The stage fires when it holds an item and the output register can take its result.
    // The input register reloads in that same cycle, so items follow back to back.
    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_value_reg;

    assign in_valid_next  = s_accept || (in_valid_reg && !out_ready);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    // Ramp and triangle share one multiplier: the step is the slope, negated while the
    // triangle is falling, times the elapsed milliseconds, added to the fed back value.
    logic signed [STEP_BITS-1:0]    step;
    logic signed [ELAPSED_BITS:0]   elapsed_s;
    logic signed [STEP_PROD-1:0]    step_prod;
    logic signed [SUM_BITS-1:0]     ramp_sum;
    logic signed [SUM_BITS-1:0]     high_ext;
    logic signed [VALUE_BITS-1:0]   tri_hi;
    logic signed [VALUE_BITS-1:0]   tri_lo;
    logic                           ramp_over;

    always_comb begin
        if (mode_reg == MODE_TRIANGLE && falling_reg) begin
            step = -STEP_BITS'(slope_reg);
        end else begin
            step = STEP_BITS'(slope_reg);
        end
    end

    assign elapsed_s = $signed({1'b0, in_elapsed_reg});
    assign step_prod = step * elapsed_s;
    assign ramp_sum  = SUM_BITS'(in_prev_reg) + SUM_BITS'(step_prod);
    assign high_ext  = SUM_BITS'(level_high_reg);
    assign tri_hi    = (level_low_reg > level_high_reg) ? level_low_reg : level_high_reg;
    assign tri_lo    = (level_low_reg < level_high_reg) ? level_low_reg : level_high_reg;
    assign ramp_over = (slope_reg > 32'sd0 && ramp_sum > high_ext) ||
                       (slope_reg < 32'sd0 && ramp_sum < high_ext);

    // Sine: the top two phase bits pick the quadrant, the rest index the quarter-wave
    // table, mirrored in odd quadrants and negated in the second half of the turn.
    logic [1:0]                     quad;
    logic [IDX_PROD_BITS-1:0]       idx_prod;
    logic [SINE_IDX_BITS-1:0]       sine_idx;
    logic [SINE_IDX_BITS:0]         mirror_idx;
    logic [SINE_MAG_BITS-1:0]       sine_mag;
    logic signed [SINE_S_BITS-1:0]  sine_s;
    logic signed [SINE_PROD-1:0]    sine_prod;
    logic signed [SINE_PROD-1:0]    sine_half;
    logic signed [ROUND_BITS-1:0]   sine_round;
    logic signed [BIAS_SUM-1:0]     sine_sum;
    logic signed [VALUE_BITS-1:0]   sine_sat;

    assign quad       = phase_reg[PHASE_BITS-1:QUAD_SHIFT];
    assign idx_prod   = IDX_PROD_BITS'(phase_reg[QUAD_SHIFT-1:0]) *
                        IDX_PROD_BITS'(SINE_ENTRIES);
    assign sine_idx   = idx_prod[QUAD_SHIFT +: SINE_IDX_BITS];
    assign mirror_idx = (SINE_IDX_BITS+1)'(SINE_ENTRIES) - {1'b0, sine_idx};

    always_comb begin
        if (!quad[0]) begin
            sine_mag = SINE_TABLE[sine_idx];
        end else if (sine_idx == '0) begin
            sine_mag = SINE_FULL;
        end else begin
            sine_mag = SINE_TABLE[mirror_idx[SINE_IDX_BITS-1:0]];
        end
    end

    assign sine_s     = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
    assign sine_prod  = sine_s * level_high_reg;
    // Round half up, then drop the 16 fraction bits of the table scale.
    assign sine_half  = sine_prod + SINE_PROD'(32768);
    assign sine_round = sine_half[SINE_PROD-1:16];
    assign sine_sum   = BIAS_SUM'(sine_round) + BIAS_SUM'(slope_reg);

    always_comb begin
        if (sine_sum[BIAS_SUM-1:VALUE_BITS-1] == '0 ||
            sine_sum[BIAS_SUM-1:VALUE_BITS-1] == '1) begin
            sine_sat = sine_sum[VALUE_BITS-1:0];
        end else if (sine_sum[BIAS_SUM-1]) begin
            sine_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            sine_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    logic [PH_PROD_BITS-1:0] phase_prod;
    assign phase_prod = phase_step_reg * in_elapsed_reg;

    // Pulse and PWM frame counting. A saturated counter is past every pulse frame.
    logic                  fc_at_max;
    logic [COUNT_BITS:0]   pulse_end;
    logic                  one_hit;
    logic                  n_hit;
    logic [COUNT_BITS-1:0] fc_sat_inc;
    logic [COUNT_BITS:0]   pwm_nc;
    logic                  pwm_wrap;
    logic                  pwm_high;

    assign fc_at_max  = frame_count_reg == COUNT_MAX;
    assign pulse_end  = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign one_hit    = frame_count_reg == count_a_reg && !fc_at_max;
    assign n_hit      = frame_count_reg >= count_a_reg &&
                        {1'b0, frame_count_reg} < pulse_end && !fc_at_max;
    assign fc_sat_inc = fc_at_max ? frame_count_reg : frame_count_reg + 1'b1;
    assign pwm_nc     = {1'b0, frame_count_reg} + 1'b1;
    assign pwm_wrap   = pwm_nc >= {1'b0, count_a_reg};
    assign pwm_high   = pwm_nc >= {1'b0, count_b_reg};

    logic signed [VALUE_BITS-1:0] result_value;

    always_comb begin
        result_value     = in_prev_reg;
        frame_count_next = frame_count_reg;
        phase_next       = phase_reg;
        falling_next     = falling_reg;
        first_tick_next  = first_tick_reg;
        if (fire) begin
            if (in_req_reg == REQ_RESTART) begin
                frame_count_next = (mode_reg == MODE_PWM_NOW) ? count_a_reg : '0;
                phase_next       = '0;
                falling_next     = 1'b0;
                unique case (mode_reg)
                    MODE_HOLD:               result_value = in_prev_reg;
                    MODE_SINE:               result_value = slope_reg;
                    MODE_PWM, MODE_PWM_NOW:  result_value = level_high_reg;
                    MODE_RAMP, MODE_RAMP_HOLD, MODE_TRIANGLE,
                    MODE_ONE_SHOT, MODE_N_SHOT: result_value = level_low_reg;
                    default:                 result_value = in_prev_reg;
                endcase
            end else if (!in_run_reg || first_tick_reg) begin
                // A stopped tick and the first running tick pass the value through.
                result_value    = in_prev_reg;
                first_tick_next = !in_run_reg;
            end else begin
                unique case (mode_reg)
                    MODE_RAMP, MODE_RAMP_HOLD: begin
                        if (ramp_over) begin
                            result_value = (mode_reg == MODE_RAMP) ? level_low_reg
                                                                   : level_high_reg;
                        end else begin
                            result_value = ramp_sum[VALUE_BITS-1:0];
                        end
                    end
                    MODE_TRIANGLE: begin
                        if (ramp_sum > SUM_BITS'(tri_hi)) begin
                            result_value = tri_hi;
                            falling_next = !falling_reg;
                        end else if (ramp_sum < SUM_BITS'(tri_lo)) begin
                            result_value = tri_lo;
                            falling_next = !falling_reg;
                        end else begin
                            result_value = ramp_sum[VALUE_BITS-1:0];
                        end
                    end
                    MODE_SINE: begin
                        result_value = sine_sat;
                        phase_next   = phase_reg + phase_prod[PHASE_BITS-1:0];
                    end
                    MODE_ONE_SHOT: begin
                        result_value     = one_hit ? level_high_reg : level_low_reg;
                        frame_count_next = fc_sat_inc;
                    end
                    MODE_N_SHOT: begin
                        result_value     = n_hit ? level_high_reg : level_low_reg;
                        frame_count_next = fc_sat_inc;
                    end
                    MODE_PWM, MODE_PWM_NOW: begin
                        if (pwm_wrap) begin
                            result_value     = level_low_reg;
                            frame_count_next = '0;
                        end else begin
                            if (pwm_high) begin
                                result_value = level_high_reg;
                            end
                            frame_count_next = pwm_nc[COUNT_BITS-1:0];
                        end
                    end
                    default: result_value = in_prev_reg;
                endcase
            end
        end
        // A mode write restarts the triangle rising and preloads the immediate PWM count.
        if (cfg_we && cfg_index == CFG_MODE) begin
            falling_next = 1'b0;
            if (cfg_data[3:0] == MODE_PWM_NOW) begin
                frame_count_next = count_a_reg;
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            frame_count_reg <= '0;
            phase_reg       <= '0;
            falling_reg     <= 1'b0;
            first_tick_reg  <= 1'b1;
            mode_reg        <= MODE_HOLD;
            level_low_reg   <= '0;
            level_high_reg  <= '0;
            slope_reg       <= '0;
            phase_step_reg  <= '0;
            count_a_reg     <= '0;
            count_b_reg     <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            frame_count_reg <= frame_count_next;
            phase_reg       <= phase_next;
            falling_reg     <= falling_next;
            first_tick_reg  <= first_tick_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MODE:          mode_reg       <= mode_t'(cfg_data[3:0]);
                    CFG_LEVEL_LOW:     level_low_reg  <= cfg_data;
                    CFG_LEVEL_HIGH:    level_high_reg <= cfg_data;
                    CFG_SLOPE_OR_BIAS: slope_reg      <= cfg_data;
                    CFG_PHASE_STEP:    phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                    CFG_COUNT_A:       count_a_reg    <= cfg_data[COUNT_BITS-1:0];
                    CFG_COUNT_B:       count_b_reg    <= cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg     <= req_type_t'(s_tuser);
            in_run_reg     <= s_tdata[0];
            in_elapsed_reg <= s_tdata[ELAPSED_BITS:1];
            in_prev_reg    <= s_tdata[ELAPSED_BITS+VALUE_BITS:ELAPSED_BITS+1];
        end
        if (fire) begin
            out_value_reg <= result_value;
        end
    end

    // An item in the input register is never dropped while the output side stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg)
        else $error("input item lost while output stalled");

    // A stopped tick or the first running tick passes the fed back value through.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_req_reg == REQ_TICK && (!in_run_reg || first_tick_reg)
        |=> out_value_reg == $past(in_prev_reg))
        else $error("held tick did not pass the value through");

    // A restart outside immediate PWM clears the frame counter and phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_req_reg == REQ_RESTART && mode_reg != MODE_PWM_NOW && !cfg_we
        |=> frame_count_reg == '0 && phase_reg == '0 && !falling_reg)
        else $error("restart did not clear the generator state");

    // Pulse modes count frames upward only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_req_reg == REQ_TICK && !cfg_we &&
        (mode_reg == MODE_ONE_SHOT || mode_reg == MODE_N_SHOT)
        |=> frame_count_reg >= $past(frame_count_reg))
        else $error("pulse frame counter went backward");

endmodule

`default_nettype wire
